@@ rtl/core/arpr_pkg.sv @@
// ----------------------------------------------------------------------------
// arpr_pkg
// Shared types and constants of the ARP responder with address cache.
// ----------------------------------------------------------------------------
package arpr_pkg;

    localparam int CACHE_ENTRIES = 16;
    localparam int CACHE_IDX_W   = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int QUEUE_DEPTH   = 2;

    localparam int MAC_W = 48;
    localparam int IP_W  = 32;

    localparam logic [15:0] HW_ETHERNET = 16'h0001;
    localparam logic [15:0] PROTO_IPV4  = 16'h0800;
    localparam logic [7:0]  HLEN_ETH    = 8'd6;
    localparam logic [7:0]  PLEN_IPV4   = 8'd4;
    localparam logic [10:0] HDR_BYTES   = 11'd8;
    localparam logic [15:0] OP_REQUEST  = 16'd1;
    localparam logic [15:0] OP_REPLY    = 16'd2;

    localparam logic FUNC_PACKET = 1'b0;
    localparam logic FUNC_QUERY  = 1'b1;

    localparam logic REG_LOCAL_MAC = 1'b0;
    localparam logic REG_LOCAL_IP  = 1'b1;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SHORT    = 3'd1,
        ST_BAD_TYPE = 3'd2,
        ST_BAD_LEN  = 3'd3,
        ST_BAD_OP   = 3'd4,
        ST_FULL     = 3'd5,
        ST_NOT_OURS = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        CMD_DONE   = 2'd0,
        CMD_QUERY  = 2'd1,
        CMD_INSERT = 2'd2
    } kind_t;

    typedef struct packed {
        status_t           status;
        logic              reply_valid;
        logic [MAC_W-1:0]  reply_dst_mac;
        logic [IP_W-1:0]   reply_dst_ip;
        logic [MAC_W-1:0]  reply_src_mac;
        logic [IP_W-1:0]   reply_src_ip;
        logic              lookup_hit;
        logic [MAC_W-1:0]  lookup_mac;
    } result_t;

    typedef struct packed {
        kind_t             kind;
        result_t           res;
        logic [IP_W-1:0]   key_ip;
        logic [MAC_W-1:0]  ins_mac;
    } cmd_t;

endpackage

@@ rtl/core/arpr_front.sv @@
// ----------------------------------------------------------------------------
// arpr_front
// Checks one input beat and turns it into a cache command or a finished result.
// ----------------------------------------------------------------------------
module arpr_front (
    input  logic                        func,
    input  logic [15:0]                 hw_type,
    input  logic [15:0]                 proto_type,
    input  logic [7:0]                  hw_len,
    input  logic [7:0]                  proto_len,
    input  logic [15:0]                 opcode,
    input  logic [15:0]                 frame_len,
    input  logic [arpr_pkg::MAC_W-1:0]  sender_mac,
    input  logic [arpr_pkg::IP_W-1:0]   sender_ip,
    input  logic [arpr_pkg::IP_W-1:0]   target_ip,
    input  logic [arpr_pkg::IP_W-1:0]   query_ip,
    input  logic [arpr_pkg::MAC_W-1:0]  local_mac,
    input  logic [arpr_pkg::IP_W-1:0]   local_ip,
    output arpr_pkg::cmd_t              cmd
);

    logic [10:0] len_need;
    logic        is_short;

    assign len_need = arpr_pkg::HDR_BYTES + {2'b00, hw_len, 1'b0} + {2'b00, proto_len, 1'b0};
    assign is_short = {5'b00000, len_need} > frame_len;

    always_comb
    begin
        cmd         = '0;
        cmd.kind    = arpr_pkg::CMD_DONE;
        cmd.ins_mac = sender_mac;
        cmd.key_ip  = sender_ip;
        cmd.res.status = arpr_pkg::ST_OK;
        if (func == arpr_pkg::FUNC_QUERY)
        begin
            cmd.kind   = arpr_pkg::CMD_QUERY;
            cmd.key_ip = query_ip;
        end
        else if (is_short)
        begin
            cmd.res.status = arpr_pkg::ST_SHORT;
        end
        else if (hw_type != arpr_pkg::HW_ETHERNET || proto_type != arpr_pkg::PROTO_IPV4)
        begin
            cmd.res.status = arpr_pkg::ST_BAD_TYPE;
        end
        else if (hw_len != arpr_pkg::HLEN_ETH || proto_len != arpr_pkg::PLEN_IPV4)
        begin
            cmd.res.status = arpr_pkg::ST_BAD_LEN;
        end
        else if (opcode == arpr_pkg::OP_REQUEST)
        begin
            if (target_ip == local_ip)
            begin
                cmd.res.reply_valid   = 1'b1;
                cmd.res.reply_dst_mac = sender_mac;
                cmd.res.reply_dst_ip  = sender_ip;
                cmd.res.reply_src_mac = local_mac;
                cmd.res.reply_src_ip  = local_ip;
            end
            else
            begin
                cmd.res.status = arpr_pkg::ST_NOT_OURS;
            end
        end
        else if (opcode == arpr_pkg::OP_REPLY)
        begin
            cmd.kind = arpr_pkg::CMD_INSERT;
        end
        else
        begin
            cmd.res.status = arpr_pkg::ST_BAD_OP;
        end
    end

endmodule

@@ rtl/core/arpr_queue.sv @@
// ----------------------------------------------------------------------------
// arpr_queue
// Short command queue between the classifier and the cache engine.
// ----------------------------------------------------------------------------
module arpr_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  arpr_pkg::cmd_t  push_cmd,
    output logic            pop_valid,
    input  logic            pop_ready,
    output arpr_pkg::cmd_t  pop_cmd
);

    localparam int PTR_W = (arpr_pkg::QUEUE_DEPTH > 1) ? $clog2(arpr_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(arpr_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(arpr_pkg::QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(arpr_pkg::QUEUE_DEPTH);

    arpr_pkg::cmd_t    slot_reg [arpr_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    property p_count_bound;
        @(posedge clk) disable iff (!rst_n) count_reg <= CNT_FULL;
    endproperty
    a_count_bound: assert property (p_count_bound)
        else $error("queue count above depth");

    property p_no_push_when_full;
        @(posedge clk) disable iff (!rst_n)
            (count_reg == CNT_FULL && !do_pop) |=> (count_reg == CNT_FULL);
    endproperty
    a_no_push_when_full: assert property (p_no_push_when_full)
        else $error("full queue lost an entry");

    property p_empty_after_last_pop;
        @(posedge clk) disable iff (!rst_n)
            (count_reg == CNT_W'(1) && do_pop && !do_push) |=> !pop_valid;
    endproperty
    a_empty_after_last_pop: assert property (p_empty_after_last_pop)
        else $error("queue not empty after last pop");

endmodule

@@ rtl/core/arpr_back.sv @@
// ----------------------------------------------------------------------------
// arpr_back
// Cache engine: searches, inserts and looks up entries, holds the result beat.
// ----------------------------------------------------------------------------
module arpr_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  arpr_pkg::cmd_t     cmd,
    output logic               res_valid,
    input  logic               res_ready,
    output arpr_pkg::result_t  res
);

    localparam int N  = arpr_pkg::CACHE_ENTRIES;
    localparam int IW = arpr_pkg::CACHE_IDX_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COMPARE,
        S_RESOLVE,
        S_READ,
        S_HOLD
    } state_t;

    state_t                     state_reg;
    state_t                     state_next;
    arpr_pkg::cmd_t             cmd_reg;
    arpr_pkg::cmd_t             cmd_next;
    arpr_pkg::result_t          out_reg;
    arpr_pkg::result_t          out_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [N-1:0]               match_reg;
    logic [N-1:0]               match_next;
    logic [N-1:0]               entry_valid_reg;
    logic [arpr_pkg::IP_W-1:0]  entry_ip_reg [N];
    logic [arpr_pkg::MAC_W-1:0] entry_mac_mem [N];
    logic [arpr_pkg::MAC_W-1:0] rd_mac_reg;
    logic [IW-1:0]              hit_idx;
    logic                       hit;
    logic [IW-1:0]              free_idx;
    logic                       free_found;
    logic                       ins_we;

    assign cmd_ready = (state_reg == S_IDLE);
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    always_comb
    begin
        hit_idx    = '0;
        free_idx   = '0;
        free_found = 1'b0;
        hit        = |match_reg;
        for (int k = N - 1; k >= 0; k--)
        begin
            if (match_reg[k])
            begin
                hit_idx = IW'(k);
            end
            if (!entry_valid_reg[k])
            begin
                free_idx   = IW'(k);
                free_found = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        out_next   = out_reg;
        match_next = match_reg;
        ins_we     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next   = cmd;
                    out_next   = cmd.res;
                    state_next = (cmd.kind == arpr_pkg::CMD_DONE) ? S_HOLD : S_COMPARE;
                end
            end
            S_COMPARE:
            begin
                for (int k = 0; k < N; k++)
                begin
                    match_next[k] = entry_valid_reg[k] && (entry_ip_reg[k] == cmd_reg.key_ip);
                end
                state_next = S_RESOLVE;
            end
            S_RESOLVE:
            begin
                state_next = S_HOLD;
                if (cmd_reg.kind == arpr_pkg::CMD_QUERY)
                begin
                    if (hit)
                    begin
                        state_next = S_READ;
                    end
                end
                else if (!hit)
                begin
                    if (free_found)
                    begin
                        ins_we = 1'b1;
                    end
                    else
                    begin
                        out_next.status = arpr_pkg::ST_FULL;
                    end
                end
            end
            S_READ:
            begin
                out_next.lookup_hit = 1'b1;
                out_next.lookup_mac = rd_mac_reg;
                state_next          = S_HOLD;
            end
            S_HOLD:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        out_valid_next = (state_next == S_HOLD);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmd_reg       <= '0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
            match_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            out_reg       <= out_next;
            out_valid_reg <= out_valid_next;
            match_reg     <= match_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
        end
        else if (ins_we)
        begin
            entry_valid_reg[free_idx] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ins_we)
        begin
            entry_ip_reg[free_idx] <= cmd_reg.key_ip;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ins_we)
        begin
            entry_mac_mem[free_idx] <= cmd_reg.ins_mac;
        end
        rd_mac_reg <= entry_mac_mem[hit_idx];
    end

    property p_unique_match;
        @(posedge clk) disable iff (!rst_n) $onehot0(match_reg);
    endproperty
    a_unique_match: assert property (p_unique_match)
        else $error("cached IP present in more than one entry");

    property p_full_means_full;
        @(posedge clk) disable iff (!rst_n)
            (out_valid_reg && out_reg.status == arpr_pkg::ST_FULL) |-> (&entry_valid_reg);
    endproperty
    a_full_means_full: assert property (p_full_means_full)
        else $error("cache full reported with a free entry");

    property p_valid_in_hold;
        @(posedge clk) disable iff (!rst_n) out_valid_reg == (state_reg == S_HOLD);
    endproperty
    a_valid_in_hold: assert property (p_valid_in_hold)
        else $error("result valid out of step with hold state");

endmodule

@@ rtl/core/arp_responder_with_cache.sv @@
// ----------------------------------------------------------------------------
// arp_responder_with_cache
// Each accepted input beat gives exactly one result beat, in order. Request
// checks and reply building finish in the classifier, so such beats go
// straight to the cache engine's hold state; an ARP reply (cache insert)
// and a cache query pass through the engine's compare and resolve steps
// over the 16 entries, and a query that hits adds a MAC read step. A 2-deep
// command queue lets input beats be taken while a result waits on out_ready.
// Write local_mac and local_ip only while the block is idle.
// ----------------------------------------------------------------------------
module arp_responder_with_cache (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [arpr_pkg::MAC_W-1:0]  cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        func,
    input  logic [15:0]                 hw_type,
    input  logic [15:0]                 proto_type,
    input  logic [7:0]                  hw_len,
    input  logic [7:0]                  proto_len,
    input  logic [15:0]                 opcode,
    input  logic [15:0]                 frame_len,
    input  logic [arpr_pkg::MAC_W-1:0]  sender_mac,
    input  logic [arpr_pkg::IP_W-1:0]   sender_ip,
    input  logic [arpr_pkg::IP_W-1:0]   target_ip,
    input  logic [arpr_pkg::IP_W-1:0]   query_ip,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [2:0]                  status,
    output logic                        reply_valid,
    output logic [arpr_pkg::MAC_W-1:0]  reply_dst_mac,
    output logic [arpr_pkg::IP_W-1:0]   reply_dst_ip,
    output logic [arpr_pkg::MAC_W-1:0]  reply_src_mac,
    output logic [arpr_pkg::IP_W-1:0]   reply_src_ip,
    output logic                        lookup_hit,
    output logic [arpr_pkg::MAC_W-1:0]  lookup_mac
);

    logic [arpr_pkg::MAC_W-1:0] local_mac_reg;
    logic [arpr_pkg::IP_W-1:0]  local_ip_reg;
    arpr_pkg::cmd_t             front_cmd;
    arpr_pkg::cmd_t             q_cmd;
    logic                       q_valid;
    logic                       q_ready;
    arpr_pkg::result_t          res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_mac_reg <= '0;
            local_ip_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                arpr_pkg::REG_LOCAL_MAC: local_mac_reg <= cfg_data;
                arpr_pkg::REG_LOCAL_IP:  local_ip_reg  <= cfg_data[arpr_pkg::IP_W-1:0];
                default:                 local_mac_reg <= local_mac_reg;
            endcase
        end
    end

    arpr_front u_front (
        .func       (func),
        .hw_type    (hw_type),
        .proto_type (proto_type),
        .hw_len     (hw_len),
        .proto_len  (proto_len),
        .opcode     (opcode),
        .frame_len  (frame_len),
        .sender_mac (sender_mac),
        .sender_ip  (sender_ip),
        .target_ip  (target_ip),
        .query_ip   (query_ip),
        .local_mac  (local_mac_reg),
        .local_ip   (local_ip_reg),
        .cmd        (front_cmd)
    );

    arpr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (in_valid),
        .push_ready (in_ready),
        .push_cmd   (front_cmd),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_cmd    (q_cmd)
    );

    arpr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .res_valid (out_valid),
        .res_ready (out_ready),
        .res       (res)
    );

    assign status        = res.status;
    assign reply_valid   = res.reply_valid;
    assign reply_dst_mac = res.reply_dst_mac;
    assign reply_dst_ip  = res.reply_dst_ip;
    assign reply_src_mac = res.reply_src_mac;
    assign reply_src_ip  = res.reply_src_ip;
    assign lookup_hit    = res.lookup_hit;
    assign lookup_mac    = res.lookup_mac;

endmodule
